### hw/rtl/gcpd_pkg.sv
`default_nettype none
package gcpd_pkg;

   // Sizes of the decoder.
   localparam int MAX_POSTURES = 16;
   localparam int MAX_CONTACTS = 5;
   localparam int PAYLOAD_CAP  = 2 * MAX_CONTACTS + 2;
   localparam int ADDR_W       = $clog2(PAYLOAD_CAP);
   localparam int IDX_W        = $clog2(PAYLOAD_CAP + 1);
   localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
   localparam int CODE_WORDS   = 4;
   localparam int CODE_W       = 64;
   localparam int LIMIT_W      = 5;
   localparam int CSR_IDX_W    = 3;

   // Byte codes on the serial link.
   localparam logic [7:0] BYTE_CONTACT = 8'h80;
   localparam logic [7:0] BYTE_TIMED   = 8'h81;
   localparam logic [7:0] BYTE_TEXT    = 8'h82;
   localparam logic [7:0] BYTE_END     = 8'h8F;
   localparam logic [7:0] CHAR_V       = 8'h56;
   localparam logic [7:0] CHAR_L       = 8'h4C;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_QUERY   = 8'h3F;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POSTURE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODES_A       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODES_B       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODES_C       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODES_D       = 3'd4;

   typedef enum logic [1:0] {
      FT_UNKNOWN,
      FT_CONTACT,
      FT_TIMED,
      FT_TEXT
   } ftype_type;

   typedef enum logic [2:0] {
      KIND_CONTACT_OK  = 3'd0,
      KIND_CONTACT_BAD = 3'd1,
      KIND_TEXT_V      = 3'd2,
      KIND_TEXT_L      = 3'd3,
      KIND_TEXT_R      = 3'd4,
      KIND_TEXT_QUERY  = 3'd5,
      KIND_TEXT_OTHER  = 3'd6
   } kind_type;

   typedef logic [PAYLOAD_CAP-1:0][7:0]       payload_type;
   typedef logic [CODE_WORDS-1:0][CODE_W-1:0] codes_type;

   // What the framer knows about the frame that the current byte belongs to.
   typedef struct packed {
      logic             close;
      ftype_type        ftype;
      logic [IDX_W-1:0] len;
      logic             overflow;
      logic [7:0]       prev_byte;
      logic [7:0]       last_byte;
   } frame_info_type;

endpackage
`default_nettype wire

### hw/rtl/gcpd_framer.sv
`default_nettype none
module gcpd_framer import gcpd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     rx_byte,
   output frame_info_type      info,
   output payload_type         payload
);

   logic             open_ff;
   ftype_type        ftype_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             overflow_ff;
   payload_type      store_ff;
   logic [7:0]       prev_ff;
   logic [7:0]       last_ff;

   logic is_end;
   logic has_room;

   assign is_end   = (rx_byte == BYTE_END);
   assign has_room = (idx_ff < IDX_W'(PAYLOAD_CAP));

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         ftype_ff    <= FT_UNKNOWN;
         idx_ff      <= '0;
         overflow_ff <= 1'b0;
      end else if (step) begin
         if (!open_ff) begin
            if (!is_end) begin
               open_ff     <= 1'b1;
               idx_ff      <= '0;
               overflow_ff <= 1'b0;
               unique case (rx_byte)
                  BYTE_CONTACT: ftype_ff <= FT_CONTACT;
                  BYTE_TIMED:   ftype_ff <= FT_TIMED;
                  BYTE_TEXT:    ftype_ff <= FT_TEXT;
                  default:      ftype_ff <= FT_UNKNOWN;
               endcase
            end
         end else if (!is_end) begin
            if (has_room) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end else begin
            open_ff <= 1'b0;
         end
      end
   end

   // Payload bytes and the two most recent ones, which hold the tick count.
   always_ff @(posedge clock) begin
      if (step && open_ff && !is_end && has_room) begin
         store_ff[idx_ff[ADDR_W-1:0]] <= rx_byte;
         prev_ff                      <= last_ff;
         last_ff                      <= rx_byte;
      end
   end

   assign info.close     = open_ff && is_end;
   assign info.ftype     = ftype_ff;
   assign info.len       = idx_ff;
   assign info.overflow  = overflow_ff;
   assign info.prev_byte = prev_ff;
   assign info.last_byte = last_ff;
   assign payload        = store_ff;

endmodule
`default_nettype wire

### hw/rtl/gcpd_matcher.sv
`default_nettype none
module gcpd_matcher import gcpd_pkg::*; (
   input  wire payload_type              payload,
   input  wire logic [CNT_W-1:0]         pair_count,
   input  wire logic [LIMIT_W-1:0]       limit,
   input  wire codes_type                codes,
   input  wire logic [MAX_POSTURES-1:0]  state,
   output logic [MAX_POSTURES-1:0]       fresh
);

   // Every posture below the limit is checked against every pair of the frame at once; the others keep their state.
   always_comb begin
      logic [15:0] code;
      logic        hit;
      for (int p = 0; p < MAX_POSTURES; p++) begin
         code = codes[p / 4][(p % 4) * 16 +: 16];
         hit  = 1'b0;
         for (int c = 0; c < MAX_CONTACTS; c++) begin
            if (CNT_W'(c) < pair_count && payload[2 * c] == code[15:8]
                && payload[2 * c + 1] == code[7:0]) begin
               hit = 1'b1;
            end
         end
         fresh[p] = (LIMIT_W'(p) < limit) ? hit : state[p];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/glove_contact_packet_posture_decoder.sv
`default_nettype none
// A byte is held in the input register; its result, if any, is registered in the result register.
// One byte per cycle while not stalled; only the end byte of a known-type frame yields a beat.
// The input register keeps taking bytes while a result waits, until an end byte must wait too.
// Reset (synchronous, active high) closes any open frame and clears the valid flags, the
// configuration, posture bits, pair and bad-frame counts; payload store, result data not cleared.
module glove_contact_packet_posture_decoder import gcpd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_frame_kind,
   output logic [15:0]               rsp_posture_bits,
   output logic [15:0]               rsp_changed_bits,
   output logic [2:0]                rsp_contact_count,
   output logic                      rsp_timed,
   output logic [13:0]               rsp_tick_count,
   output logic [15:0]               rsp_bad_frames,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CODE_W-1:0]    csr_wdata
);

   // Configuration registers.
   logic [LIMIT_W-1:0] posture_count_ff;
   codes_type          codes_ff;

   // Input register: the byte waiting to be decoded.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Decoder state that outlives a frame.
   logic [MAX_POSTURES-1:0] posture_state_ff;
   logic [CNT_W-1:0]        last_contacts_ff;
   logic [15:0]             bad_total_ff;

   // Result register.
   logic        rsp_valid_ff;
   kind_type    kind_ff;
   logic [15:0] posture_bits_ff;
   logic [15:0] changed_bits_ff;
   logic [2:0]  contact_count_ff;
   logic        timed_ff;
   logic [13:0] tick_ff;
   logic [15:0] bad_frames_ff;

   frame_info_type          info;
   payload_type             payload;
   logic [MAX_POSTURES-1:0] fresh;
   logic [LIMIT_W-1:0]      limit;
   logic [IDX_W-1:0]        pair_len;
   logic [CNT_W-1:0]        pairs;
   logic                    timed;
   logic                    bad;
   logic                    emit;
   logic                    out_free;
   logic                    advance;
   logic [15:0]             bad_total_in;
   kind_type                text_kind;

   // The byte in the input register moves on unless it closes a frame of known type and the
   // result register is still occupied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = info.close && (info.ftype != FT_UNKNOWN);
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         posture_count_ff <= '0;
         codes_ff         <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POSTURE_COUNT: posture_count_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_CODES_A:       codes_ff[0]      <= csr_wdata;
            CSR_CODES_B:       codes_ff[1]      <= csr_wdata;
            CSR_CODES_C:       codes_ff[2]      <= csr_wdata;
            CSR_CODES_D:       codes_ff[3]      <= csr_wdata;
            default: ;
         endcase
      end
   end

   gcpd_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .info    (info),
      .payload (payload)
   );

   // A contact frame is bad when its payload is odd, overflows the store, holds
   // too many pairs, or is a timed frame too short to carry its tick count.
   assign timed = (info.ftype == FT_TIMED);
   always_comb begin
      bad = info.overflow || info.len[0];
      if (timed) begin
         bad = bad || (info.len < IDX_W'(2));
      end else begin
         bad = bad || (info.len > IDX_W'(2 * MAX_CONTACTS + 1));
      end
   end

   assign pair_len = timed ? info.len - IDX_W'(2) : info.len;
   assign pairs    = pair_len[CNT_W:1];
   assign limit    = (posture_count_ff > LIMIT_W'(MAX_POSTURES)) ?
                     LIMIT_W'(MAX_POSTURES) : posture_count_ff;
   assign bad_total_in = (bad_total_ff == 16'hFFFF) ? bad_total_ff :
                         bad_total_ff + 16'd1;

   gcpd_matcher u_matcher (
      .payload    (payload),
      .pair_count (pairs),
      .limit      (limit),
      .codes      (codes_ff),
      .state      (posture_state_ff),
      .fresh      (fresh)
   );

   // A text frame is classed by its first character; an empty one is other text.
   always_comb begin
      text_kind = KIND_TEXT_OTHER;
      if (info.len != '0) begin
         unique case (payload[0])
            CHAR_V:     text_kind = KIND_TEXT_V;
            CHAR_L:     text_kind = KIND_TEXT_L;
            CHAR_R:     text_kind = KIND_TEXT_R;
            CHAR_QUERY: text_kind = KIND_TEXT_QUERY;
            default:    text_kind = KIND_TEXT_OTHER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         posture_state_ff <= '0;
         last_contacts_ff <= '0;
         bad_total_ff     <= '0;
      end else if (advance && emit && info.ftype != FT_TEXT) begin
         if (bad) begin
            bad_total_ff <= bad_total_in;
         end else begin
            posture_state_ff <= fresh;
            last_contacts_ff <= pairs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: the text case and the bad case leave the posture bits and
   // the pair count as they stand and report a tick count of zero.
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         posture_bits_ff  <= 16'(posture_state_ff);
         changed_bits_ff  <= '0;
         contact_count_ff <= 3'(last_contacts_ff);
         timed_ff         <= timed;
         tick_ff          <= '0;
         bad_frames_ff    <= bad_total_ff;
         if (info.ftype == FT_TEXT) begin
            kind_ff <= text_kind;
         end else if (bad) begin
            kind_ff       <= KIND_CONTACT_BAD;
            bad_frames_ff <= bad_total_in;
         end else begin
            kind_ff          <= KIND_CONTACT_OK;
            posture_bits_ff  <= 16'(fresh);
            changed_bits_ff  <= 16'(fresh ^ posture_state_ff);
            contact_count_ff <= 3'(pairs);
            if (timed) begin
               tick_ff <= {info.last_byte[6:0], info.prev_byte[6:0]};
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_kind    = kind_ff;
   assign rsp_posture_bits  = posture_bits_ff;
   assign rsp_changed_bits  = changed_bits_ff;
   assign rsp_contact_count = contact_count_ff;
   assign rsp_timed         = timed_ff;
   assign rsp_tick_count    = tick_ff;
   assign rsp_bad_frames    = bad_frames_ff;

endmodule
`default_nettype wire
